// ===== rtl/rectangle_fill_outline_raster_macros.svh =====
// Assertion macros shared by the rasterizer modules.
`ifndef RECTANGLE_FILL_OUTLINE_RASTER_MACROS_SVH
`define RECTANGLE_FILL_OUTLINE_RASTER_MACROS_SVH

// Same-cycle property, checked outside reset.
`define RFOR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define RFOR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rfor_pkg.sv =====
// Types and constants shared by the rasterizer modules.
`timescale 1ns / 1ps
package rfor_pkg;

    localparam int EDGE_W      = 26;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] ACT_DRAW  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] STAT_OK           = 2'd0;
    localparam logic [1:0] STAT_ZERO_SIZE    = 2'd1;
    localparam logic [1:0] STAT_OUT_OF_RANGE = 2'd2;

    localparam logic [1:0] CFG_WIDTH      = 2'd0;
    localparam logic [1:0] CFG_HEIGHT     = 2'd1;
    localparam logic [1:0] CFG_BACKGROUND = 2'd2;

    localparam logic [7:0] NEWLINE_CHAR     = 8'd10;
    localparam logic [7:0] RESET_BACKGROUND = 8'd32;
    localparam logic [8:0] RESET_DIM        = 9'd256;

    // Slots of the coordinate bus between front and back.
    localparam int CRD_X0 = 0;
    localparam int CRD_X1 = 1;
    localparam int CRD_Y0 = 2;
    localparam int CRD_Y1 = 3;

    typedef enum logic [1:0] {
        OP_REPORT,
        OP_DRAW,
        OP_READ,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } t_edges;

    typedef struct packed {
        t_op        op;
        logic [1:0] status;
        logic       filled;
        t_edges     edges;
        logic [7:0] mark;
    } t_cmd_ctl;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DRAW,
        ST_CLEAR,
        ST_READ,
        ST_RDATA,
        ST_DONE
    } t_back_state;

endpackage

// ===== rtl/rfor_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rfor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rfor_queue.sv =====
// Short command queue between the front classifier and the back sequencer.
`timescale 1ns / 1ps
`include "rectangle_fill_outline_raster_macros.svh"
module rfor_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `RFOR_ASSERT(a_q_no_overflow, !(i_push && o_full && !i_pop), "queue push while full")
    `RFOR_ASSERT(a_q_no_underflow, !(i_pop && o_empty), "queue pop while empty")
    `RFOR_ASSERT(a_q_ptr_match, (r_count != '0) || (r_wr_ptr == r_rd_ptr), "empty queue pointers differ")

endmodule

// ===== rtl/rfor_front.sv =====
// Front end: takes items, computes pixel edges and clipping, classifies them.
`timescale 1ns / 1ps
module rfor_front
    import rfor_pkg::*;
#(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic [1:0]                         i_action,
    input  logic                               i_filled,
    input  logic signed [23:0]                 i_left_x,
    input  logic signed [23:0]                 i_top_y,
    input  logic [22:0]                        i_rect_width,
    input  logic [22:0]                        i_rect_height,
    input  logic [7:0]                         i_mark_char,
    input  logic [7:0]                         i_read_column,
    input  logic [7:0]                         i_read_row,
    input  logic                               i_hold,
    input  logic [$clog2(MAX_DIM)-1:0]         i_cw_m1,
    input  logic [$clog2(MAX_DIM)-1:0]         i_ch_m1,
    input  logic [7:0]                         i_background,
    input  logic                               i_q_full,
    output logic                               o_q_push,
    output t_cmd_ctl                           o_q_ctl,
    output logic [3:0][$clog2(MAX_DIM)-1:0]    o_q_coord
);

    localparam int CW = $clog2(MAX_DIM);
    localparam logic signed [EDGE_W-1:0] FRAC_ROUND = EDGE_W'((1 << FRAC_BITS) - 1);

    logic               r_valid;
    logic [1:0]         r_action;
    logic               r_filled;
    logic signed [23:0] r_left_x;
    logic signed [23:0] r_top_y;
    logic [22:0]        r_rect_width;
    logic [22:0]        r_rect_height;
    logic [7:0]         r_mark_char;
    logic [7:0]         r_read_column;
    logic [7:0]         r_read_row;

    logic accept;
    logic push;

    logic signed [EDGE_W-1:0] lx_e, ty_e, w_e, h_e, cw_e, ch_e;
    logic signed [EDGE_W-1:0] l_sum, t_sum, r_sum, b_sum;
    logic signed [EDGE_W-1:0] l_edge, t_edge, r_edge, b_edge;
    logic                     x_empty, y_empty, r_clip, b_clip, zero_size, read_out;
    logic [CW-1:0]            x0, x1, y0, y1;
    logic [7:0]               mark;

    assign push   = r_valid && !i_q_full;
    assign o_full = i_hold || (r_valid && i_q_full);
    assign accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action      <= i_action;
            r_filled      <= i_filled;
            r_left_x      <= i_left_x;
            r_top_y       <= i_top_y;
            r_rect_width  <= i_rect_width;
            r_rect_height <= i_rect_height;
            r_mark_char   <= i_mark_char;
            r_read_column <= i_read_column;
            r_read_row    <= i_read_row;
        end
    end

    assign lx_e = EDGE_W'(r_left_x);
    assign ty_e = EDGE_W'(r_top_y);
    assign w_e  = EDGE_W'($signed({1'b0, r_rect_width}));
    assign h_e  = EDGE_W'($signed({1'b0, r_rect_height}));
    assign cw_e = EDGE_W'($signed({1'b0, i_cw_m1}));
    assign ch_e = EDGE_W'($signed({1'b0, i_ch_m1}));

    // Ceil for the near edges, floor for the far ones; arithmetic shift is an exact floor.
    assign l_sum  = lx_e + FRAC_ROUND;
    assign t_sum  = ty_e + FRAC_ROUND;
    assign r_sum  = lx_e + w_e;
    assign b_sum  = ty_e + h_e;
    assign l_edge = l_sum >>> FRAC_BITS;
    assign t_edge = t_sum >>> FRAC_BITS;
    assign r_edge = r_sum >>> FRAC_BITS;
    assign b_edge = b_sum >>> FRAC_BITS;

    assign r_clip  = (r_edge > cw_e);
    assign b_clip  = (b_edge > ch_e);
    assign x_empty = (l_edge > r_edge) || r_edge[EDGE_W-1] || (l_edge > cw_e);
    assign y_empty = (t_edge > b_edge) || b_edge[EDGE_W-1] || (t_edge > ch_e);

    assign x0 = l_edge[EDGE_W-1] ? '0 : l_edge[CW-1:0];
    assign y0 = t_edge[EDGE_W-1] ? '0 : t_edge[CW-1:0];
    assign x1 = r_clip ? i_cw_m1 : r_edge[CW-1:0];
    assign y1 = b_clip ? i_ch_m1 : b_edge[CW-1:0];

    assign zero_size = (r_rect_width == '0) || (r_rect_height == '0);
    assign read_out  = (32'(r_read_column) > 32'(i_cw_m1)) || (32'(r_read_row) > 32'(i_ch_m1));
    assign mark      = (r_mark_char == NEWLINE_CHAR) ? i_background : r_mark_char;

    always_comb begin
        o_q_ctl.op            = OP_REPORT;
        o_q_ctl.status        = STAT_OK;
        o_q_ctl.filled        = r_filled;
        o_q_ctl.edges.left    = !l_edge[EDGE_W-1];
        o_q_ctl.edges.right   = !r_clip;
        o_q_ctl.edges.top     = !t_edge[EDGE_W-1];
        o_q_ctl.edges.bottom  = !b_clip;
        o_q_ctl.mark          = mark;
        o_q_coord[CRD_X0]     = x0;
        o_q_coord[CRD_X1]     = x1;
        o_q_coord[CRD_Y0]     = y0;
        o_q_coord[CRD_Y1]     = y1;
        unique case (r_action)
            ACT_DRAW: begin
                if (zero_size) begin
                    o_q_ctl.status = STAT_ZERO_SIZE;
                end else if (!x_empty && !y_empty) begin
                    o_q_ctl.op = OP_DRAW;
                end
            end
            ACT_READ: begin
                o_q_coord[CRD_X0] = CW'(r_read_column);
                o_q_coord[CRD_Y0] = CW'(r_read_row);
                if (read_out) begin
                    o_q_ctl.status = STAT_OUT_OF_RANGE;
                end else begin
                    o_q_ctl.op = OP_READ;
                end
            end
            ACT_CLEAR: begin
                o_q_ctl.op   = OP_CLEAR;
                o_q_ctl.mark = i_background;
            end
            default: begin
                o_q_ctl.op = OP_REPORT;
            end
        endcase
    end

    assign o_q_push = push;

endmodule

// ===== rtl/rfor_back.sv =====
// Back end: sweeps the canvas memory for draws and clears, reads pixels, holds results.
`timescale 1ns / 1ps
`include "rectangle_fill_outline_raster_macros.svh"
module rfor_back
    import rfor_pkg::*;
#(
    parameter int MAX_DIM = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    output logic                            o_q_pop,
    input  t_cmd_ctl                        i_q_ctl,
    input  logic [3:0][$clog2(MAX_DIM)-1:0] i_q_coord,
    output logic                            o_init_busy,
    output logic                            o_empty,
    input  logic                            i_pop,
    output logic [1:0]                      o_status,
    output logic [7:0]                      o_pixel_char
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;

    t_back_state   r_state;
    t_back_state   n_state;
    t_cmd_ctl      r_ctl;
    logic [CW-1:0] r_x0, r_x1, r_y0, r_y1, r_x, r_y;
    logic [AW-1:0] r_addr;
    logic [7:0]    r_pixel;
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [7:0]    r_out_pixel;

    logic          x_last, y_last, addr_last, out_free, out_load, q_pop;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    assign x_last    = (r_x == r_x1);
    assign y_last    = (r_y == r_y1);
    assign addr_last = (r_addr == AW'(DEPTH - 1));
    assign out_free  = !r_out_valid || i_pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT:  if (addr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_q_ctl.op)
                        OP_DRAW:   n_state = ST_DRAW;
                        OP_READ:   n_state = ST_READ;
                        OP_CLEAR:  n_state = ST_CLEAR;
                        OP_REPORT: n_state = ST_DONE;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_DRAW:  if (x_last && y_last) n_state = ST_DONE;
            ST_CLEAR: if (addr_last) n_state = ST_DONE;
            ST_READ:  n_state = ST_RDATA;
            ST_RDATA: n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = r_ctl.mark;
        ram_re    = 1'b0;
        ram_raddr = {r_y0, r_x0};
        unique case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = RESET_BACKGROUND;
            end
            ST_IDLE: q_pop = !i_q_empty;
            ST_DRAW: begin
                // Outline keeps only pixels on an unclipped edge of the rectangle.
                ram_we    = r_ctl.filled
                         || (r_x == r_x0 && r_ctl.edges.left)
                         || (r_x == r_x1 && r_ctl.edges.right)
                         || (r_y == r_y0 && r_ctl.edges.top)
                         || (r_y == r_y1 && r_ctl.edges.bottom);
                ram_waddr = {r_y, r_x};
            end
            ST_CLEAR: ram_we = 1'b1;
            ST_READ:  ram_re = 1'b1;
            ST_RDATA: ram_re = 1'b0;
            ST_DONE:  out_load = out_free;
            default:  q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_INIT || r_state == ST_CLEAR) begin
                r_addr <= r_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_ctl <= i_q_ctl;
            r_x0  <= i_q_coord[CRD_X0];
            r_x1  <= i_q_coord[CRD_X1];
            r_y0  <= i_q_coord[CRD_Y0];
            r_y1  <= i_q_coord[CRD_Y1];
            r_x   <= i_q_coord[CRD_X0];
            r_y   <= i_q_coord[CRD_Y0];
        end else if (r_state == ST_DRAW) begin
            // Advance along the row, wrap to the next row at the right clip.
            if (x_last) begin
                r_x <= r_x0;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
        if (r_state == ST_RDATA) begin
            r_pixel <= ram_rdata;
        end
        if (out_load) begin
            r_out_status <= r_ctl.status;
            r_out_pixel  <= (r_ctl.op == OP_READ) ? r_pixel : 8'd0;
        end
    end

    rfor_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_q_pop      = q_pop;
    assign o_init_busy  = (r_state == ST_INIT);
    assign o_empty      = !r_out_valid;
    assign o_status     = r_out_status;
    assign o_pixel_char = r_out_pixel;

    `RFOR_ASSERT(a_init_no_result, (r_state != ST_INIT) || !r_out_valid, "result during clearing pass")
    `RFOR_ASSERT(a_draw_in_bounds, (r_state != ST_DRAW) || (r_x >= r_x0 && r_x <= r_x1 && r_y >= r_y0 && r_y <= r_y1), "draw scan outside clip window")
    `RFOR_ASSERT_NEXT(a_read_path, r_state == ST_READ, r_state == ST_RDATA, "read data stage skipped")
    `RFOR_ASSERT_NEXT(a_load_valid, out_load, r_out_valid && r_state == ST_IDLE, "result load lost")

endmodule

// ===== rtl/rectangle_fill_outline_raster.sv =====
// Top level of the rectangle fill and outline rasterizer.
`timescale 1ns / 1ps
// Character canvas rasterizer. Items enter through a queue-style port: an item is
// taken when push is high and full is low. Results leave the same way: while empty
// is low the oldest result is on o_status/o_pixel_char and pop takes it.
// Every item gives exactly one result, in order. Configuration (canvas width,
// height, background) goes through a valid/ready write channel that is always ready.
// Path from the accepting edge: the item is registered in the front register, then in the
// command queue, then the back end pops the command, works on it and posts the result. A
// read goes through the READ and RDATA states, a draw visits every pixel in the clipped
// box, a clear sweeps the whole canvas memory, and a zero size, empty draw or unused
// action goes straight to DONE.
// The back end works on one command at a time, from its pop until it posts the result;
// the front and the queue keep taking items meanwhile.
// The canvas memory has one write port, so draws and clears run one pixel a cycle.
// After reset the back end sweeps the whole canvas to the reset background; full stays
// high meanwhile.
// When the receiver does not pop, one result waits in the output register, the
// back end holds its next result, and the queue and front fill until full rises.
module rectangle_fill_outline_raster
    import rfor_pkg::*;
#(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_action,
    input  logic               i_filled,
    input  logic signed [23:0] i_left_x,
    input  logic signed [23:0] i_top_y,
    input  logic [22:0]        i_rect_width,
    input  logic [22:0]        i_rect_height,
    input  logic [7:0]         i_mark_char,
    input  logic [7:0]         i_read_column,
    input  logic [7:0]         i_read_row,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_status,
    output logic [7:0]         o_pixel_char,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int ENT_W = $bits(t_cmd_ctl) + 4 * CW;

    logic [8:0] r_canvas_width;
    logic [8:0] r_canvas_height;
    logic [7:0] r_background_char;

    logic                   cfg_we;
    logic [CW-1:0]          cw_m1, ch_m1;
    logic                   init_busy;
    logic                   q_push, q_pop, q_full, q_empty;
    t_cmd_ctl               f_ctl, b_ctl;
    logic [3:0][CW-1:0]     f_coord, b_coord;
    logic [ENT_W-1:0]       q_wdata, q_rdata;

    // Zero counts as one, anything above the array size as the array size.
    function automatic logic [CW-1:0] dim_m1(input logic [8:0] d);
        logic [CW-1:0] v;
        if (d == '0) begin
            v = '0;
        end else if (int'(d) > MAX_DIM) begin
            v = CW'(MAX_DIM - 1);
        end else begin
            v = CW'(d - 9'd1);
        end
        return v;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width    <= RESET_DIM;
            r_canvas_height   <= RESET_DIM;
            r_background_char <= RESET_BACKGROUND;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:      r_canvas_width    <= i_cfg_data;
                CFG_HEIGHT:     r_canvas_height   <= i_cfg_data;
                CFG_BACKGROUND: r_background_char <= i_cfg_data[7:0];
                default:        r_background_char <= r_background_char;
            endcase
        end
    end

    assign cw_m1 = dim_m1(r_canvas_width);
    assign ch_m1 = dim_m1(r_canvas_height);

    rfor_front #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_action      (i_action),
        .i_filled      (i_filled),
        .i_left_x      (i_left_x),
        .i_top_y       (i_top_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_mark_char   (i_mark_char),
        .i_read_column (i_read_column),
        .i_read_row    (i_read_row),
        .i_hold        (init_busy),
        .i_cw_m1       (cw_m1),
        .i_ch_m1       (ch_m1),
        .i_background  (r_background_char),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_ctl       (f_ctl),
        .o_q_coord     (f_coord)
    );

    assign q_wdata          = {f_ctl, f_coord};
    assign {b_ctl, b_coord} = q_rdata;

    rfor_queue #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    rfor_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_q_ctl      (b_ctl),
        .i_q_coord    (b_coord),
        .o_init_busy  (init_busy),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_status     (o_status),
        .o_pixel_char (o_pixel_char)
    );

endmodule

// ===== tb/rectangle_fill_outline_raster_test.sv =====
// Self-checking testbench for the rectangle fill and outline rasterizer.
`timescale 1ns / 1ps
module rectangle_fill_outline_raster_test;
    import rfor_pkg::*;

    localparam int MAX_DIM       = 256;
    localparam int FRAC_BITS     = 8;
    localparam int MAX_IDLE      = 14;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  action;
        logic        filled;
        logic [23:0] left_x;
        logic [23:0] top_y;
        logic [22:0] rect_width;
        logic [22:0] rect_height;
        logic [7:0]  mark_char;
        logic [7:0]  read_column;
        logic [7:0]  read_row;
    } raster_cmd_t;

    typedef struct {
        logic [1:0] status;
        logic [7:0] pixel_char;
    } raster_reply_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_action = '0;
    logic        i_filled = 1'b0;
    logic [23:0] i_left_x = '0;
    logic [23:0] i_top_y = '0;
    logic [22:0] i_rect_width = '0;
    logic [22:0] i_rect_height = '0;
    logic [7:0]  i_mark_char = '0;
    logic [7:0]  i_read_column = '0;
    logic [7:0]  i_read_row = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_pixel_char;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [8:0]  i_cfg_data = '0;

    // Mirror of the canvas and the registers
    logic [7:0]    canvas_mirror [0:MAX_DIM*MAX_DIM-1];
    logic [8:0]    canvas_cols = RESET_DIM;
    logic [8:0]    canvas_rows = RESET_DIM;
    logic [7:0]    background = RESET_BACKGROUND;
    raster_reply_t awaited_replies [$];

    int fail_count = 0;
    int cycle_count = 0;
    bit send_pace = 1'b1;
    bit take_pace = 1'b1;
    bit hold_request = 1'b0;
    bit hold_active = 1'b0;

    rectangle_fill_outline_raster uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_filled      (i_filled),
        .i_left_x      (i_left_x),
        .i_top_y       (i_top_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_mark_char   (i_mark_char),
        .i_read_column (i_read_column),
        .i_read_row    (i_read_row),
        .empty         (empty),
        .pop           (pop),
        .o_status      (o_status),
        .o_pixel_char  (o_pixel_char),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rectangle_fill_outline_raster_test: errors");
            $finish;
        end
    end

    function automatic longint to_signed24(logic [23:0] v);
        longint s;
        s = longint'(v);
        if (v[23]) s = s - 64'sd16777216;
        return s;
    endfunction

    function automatic int eff_dim(logic [8:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return int'(d);
    endfunction

    function automatic raster_cmd_t draw_cmd(bit fill, int lx, int ty, int w, int h,
                                             logic [7:0] mark);
        raster_cmd_t c;
        c = '{default: '0};
        c.action = ACT_DRAW;
        c.filled = fill;
        c.left_x = lx[23:0];
        c.top_y = ty[23:0];
        c.rect_width = w[22:0];
        c.rect_height = h[22:0];
        c.mark_char = mark;
        return c;
    endfunction

    function automatic raster_cmd_t read_cmd(int col, int row);
        raster_cmd_t c;
        c = '{default: '0};
        c.action = ACT_READ;
        c.read_column = col[7:0];
        c.read_row = row[7:0];
        return c;
    endfunction

    function automatic raster_cmd_t bare_cmd(logic [1:0] act);
        raster_cmd_t c;
        c = '{default: '0};
        c.action = act;
        return c;
    endfunction

    // Mostly rectangles near the canvas and reads inside it, with noise in unused fields
    function automatic raster_cmd_t random_cmd(int cw, int ch, bit clear_ok);
        raster_cmd_t c;
        int pick;
        c.filled = 1'($urandom);
        c.left_x = 24'($urandom);
        c.top_y = 24'($urandom);
        c.rect_width = 23'($urandom);
        c.rect_height = 23'($urandom);
        c.mark_char = 8'($urandom);
        c.read_column = 8'($urandom);
        c.read_row = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            c.action = ACT_DRAW;
            if ($urandom_range(0, 9) != 0) begin
                c.left_x = 24'($urandom_range(0, (cw + 8) * 256) - 4 * 256);
                c.top_y = 24'($urandom_range(0, (ch + 8) * 256) - 4 * 256);
                c.rect_width = 23'($urandom_range(1, (cw / 2 + 3) * 256));
                c.rect_height = 23'($urandom_range(1, (ch / 2 + 3) * 256));
            end
            case ($urandom_range(0, 15))
                0: c.rect_width = '0;
                1: c.rect_height = '0;
                default: ;
            endcase
            if ($urandom_range(0, 6) == 0) c.mark_char = NEWLINE_CHAR;
        end else if (pick < 85) begin
            c.action = ACT_READ;
            if ($urandom_range(0, 4) != 0) begin
                c.read_column = 8'($urandom_range(0, (cw < MAX_DIM) ? cw : MAX_DIM - 1));
                c.read_row = 8'($urandom_range(0, (ch < MAX_DIM) ? ch : MAX_DIM - 1));
            end
        end else if (pick >= 96 && clear_ok) begin
            c.action = ACT_CLEAR;
        end else begin
            c.action = ACT_UNUSED;
        end
        return c;
    endfunction

    // Apply one accepted command to the mirror and queue the reply it must give
    task automatic rasterize_item(input raster_cmd_t c);
        longint lx, ty, l, t, r, b, x0, x1, y0, y1, x, y, cw, ch, span;
        logic [7:0] mark;
        raster_reply_t rep;
        rep.status = STAT_OK;
        rep.pixel_char = '0;
        cw = eff_dim(canvas_cols);
        ch = eff_dim(canvas_rows);
        case (c.action)
            ACT_DRAW: begin
                if (c.rect_width == 0 || c.rect_height == 0) begin
                    rep.status = STAT_ZERO_SIZE;
                end else begin
                    mark = (c.mark_char == NEWLINE_CHAR) ? background : c.mark_char;
                    lx = to_signed24(c.left_x);
                    ty = to_signed24(c.top_y);
                    // arithmetic shift floors negative values too
                    l = (lx + (64'sd1 << FRAC_BITS) - 1) >>> FRAC_BITS;
                    t = (ty + (64'sd1 << FRAC_BITS) - 1) >>> FRAC_BITS;
                    span = longint'(c.rect_width);
                    r = (lx + span) >>> FRAC_BITS;
                    span = longint'(c.rect_height);
                    b = (ty + span) >>> FRAC_BITS;
                    x0 = (l < 0) ? 0 : l;
                    y0 = (t < 0) ? 0 : t;
                    x1 = (r > cw - 1) ? cw - 1 : r;
                    y1 = (b > ch - 1) ? ch - 1 : b;
                    for (y = y0; y <= y1; y++) begin
                        for (x = x0; x <= x1; x++) begin
                            if (c.filled || x == l || x == r || y == t || y == b)
                                canvas_mirror[y * MAX_DIM + x] = mark;
                        end
                    end
                end
            end
            ACT_READ: begin
                if (c.read_column >= cw || c.read_row >= ch)
                    rep.status = STAT_OUT_OF_RANGE;
                else
                    rep.pixel_char = canvas_mirror[c.read_row * MAX_DIM + c.read_column];
            end
            ACT_CLEAR: begin
                foreach (canvas_mirror[i]) canvas_mirror[i] = background;
            end
            default: ;
        endcase
        awaited_replies.push_back(rep);
    endtask

    task automatic send_item(input raster_cmd_t c);
        int gap;
        gap = send_pace ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_action <= c.action;
        i_filled <= c.filled;
        i_left_x <= c.left_x;
        i_top_y <= c.top_y;
        i_rect_width <= c.rect_width;
        i_rect_height <= c.rect_height;
        i_mark_char <= c.mark_char;
        i_read_column <= c.read_column;
        i_read_row <= c.read_row;
        do @(posedge i_clk); while (full);
        rasterize_item(c);
    endtask

    // Drop push and let every outstanding reply come back
    task automatic wait_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WIDTH:      canvas_cols = data;
            CFG_HEIGHT:     canvas_rows = data;
            CFG_BACKGROUND: background = data[7:0];
            default: ;
        endcase
    endtask

    task automatic set_canvas(input logic [8:0] w, input logic [8:0] h,
                              input logic [8:0] bg);
        wait_idle();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_BACKGROUND, bg);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: random pop gaps, long hold on request
    initial begin
        int gap;
        raster_reply_t want;
        wait (i_rst_n);
        forever begin
            gap = take_pace ? $urandom_range(0, MAX_IDLE) : 0;
            @(negedge i_clk);
            if (gap > 0 || hold_active) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
                while (hold_active) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (awaited_replies.size() == 0) begin
                $error("unexpected result: status %0d, pixel_char %0d", o_status, o_pixel_char);
                fail_count++;
            end else begin
                want = awaited_replies.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_pixel_char !== want.pixel_char) begin
                    $error("pixel_char: expected %0d, actual %0d", want.pixel_char,
                           o_pixel_char);
                    fail_count++;
                end
            end
        end
    end

    always begin
        wait (hold_request);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active = 1'b0;
        hold_request = 1'b0;
    end

    // Reset geometry: fractional edges, clipped outlines, negative floors, extremes
    task automatic test_reset_canvas();
        send_item(read_cmd(0, 0));
        send_item(read_cmd(255, 255));
        send_item(draw_cmd(1, 384, 128, 576, 256, "A"));
        send_item(read_cmd(3, 1));
        send_item(draw_cmd(0, -384, -384, 1024, 1024, "B"));
        send_item(read_cmd(0, 0));
        send_item(read_cmd(2, 0));
        // right edge at -0.25 must floor to -1 and draw nothing
        send_item(draw_cmd(1, -320, 1024, 256, 64, "D"));
        send_item(draw_cmd(1, -192, 768, 192, 64, "C"));
        send_item(read_cmd(0, 3));
        send_item(read_cmd(0, 4));
        send_item(draw_cmd(1, 1280, 1280, 0, 512, "Z"));
        send_item(draw_cmd(1, 1280, 1280, 512, 0, "Z"));
        send_item(bare_cmd(ACT_UNUSED));
        send_item(draw_cmd(1, 1280, 1280, 1, 1, NEWLINE_CHAR));
        send_item(draw_cmd(1, -8388608, -8388608, 8388607, 8388607, 8'hFF));
        send_item(draw_cmd(0, 8388607, 8388607, 8388607, 8388607, 8'h00));
        send_item(draw_cmd(1, 0, 0, 65536, 65536, "F"));
        send_item(draw_cmd(0, 0, 0, 65280, 65280, "G"));
        send_item(read_cmd(0, 0));
        send_item(read_cmd(128, 128));
        send_item(read_cmd(255, 17));
    endtask

    // Dimension registers at and beyond their limits, clear, newline mark
    task automatic test_dimension_registers();
        set_canvas(9'd0, 9'd511, 9'h100);
        send_item(read_cmd(0, 255));
        send_item(read_cmd(1, 0));
        send_item(draw_cmd(1, 0, 0, 768, 76800, "H"));
        send_item(read_cmd(0, 200));
        send_item(bare_cmd(ACT_CLEAR));
        send_item(read_cmd(0, 0));
        set_canvas(9'd1, 9'd1, 9'h0FF);
        send_item(draw_cmd(1, 0, 0, 256, 256, NEWLINE_CHAR));
        send_item(read_cmd(0, 0));
        send_item(read_cmd(0, 1));
        send_item(read_cmd(255, 255));
    endtask

    // Hold the result side so the block backs up and stalls its input
    task automatic test_output_stall();
        int n;
        set_canvas(9'd16, 9'd16, 9'(".") );
        hold_request = 1'b1;
        send_pace = 1'b0;
        for (n = 0; n < 16; n++) send_item(random_cmd(16, 16, 1'b0));
        send_pace = 1'b1;
    endtask

    task automatic test_random_scenes();
        int phase, counted, clears_left, cw, ch;
        logic [8:0] wreg, hreg;
        raster_cmd_t c;
        clears_left = 2;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    wreg = 9'($urandom_range(257, 511));
                    hreg = 9'($urandom_range(1, 2));
                end
                1: begin
                    wreg = 9'($urandom_range(0, 3));
                    hreg = 9'($urandom_range(200, 256));
                end
                default: begin
                    wreg = 9'($urandom_range(0, 24));
                    hreg = 9'($urandom_range(0, 24));
                end
            endcase
            set_canvas(wreg, hreg, 9'($urandom));
            cw = eff_dim(wreg);
            ch = eff_dim(hreg);
            send_pace = (phase != 2);
            take_pace = (phase != 3);
            counted = 0;
            while (counted < 10) begin
                c = random_cmd(cw, ch, clears_left > 0);
                if (c.action == ACT_CLEAR) clears_left--;
                if (c.action != ACT_UNUSED) counted++;
                send_item(c);
            end
        end
        send_pace = 1'b1;
        take_pace = 1'b1;
    endtask

    initial begin
        foreach (canvas_mirror[i]) canvas_mirror[i] = RESET_BACKGROUND;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_canvas();
        test_dimension_registers();
        test_output_stall();
        test_random_scenes();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("rectangle_fill_outline_raster_test: clean");
        else
            $display("rectangle_fill_outline_raster_test: errors");
        $finish;
    end

endmodule
